/* design/central_difference_gradient_macros.svh */
// Assertion macros for the central difference gradient block.
`ifndef CENTRAL_DIFFERENCE_GRADIENT_MACROS_SVH
`define CENTRAL_DIFFERENCE_GRADIENT_MACROS_SVH

// same-cycle implication
`define CDG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CDG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/cdg_pkg.sv */
// Shared types, constants and latency function for the gradient block.
package cdg_pkg;

   localparam int CDG_VOXEL_W = 8;
   localparam int CDG_COORD_W = 10;
   localparam int CDG_GRAD_W  = 16;

   localparam int VOXEL_BITS_DEF    = 8;
   localparam int COORD_BITS_DEF    = 10;
   localparam int FRACTION_BITS_DEF = 14;

   typedef struct packed {
      logic [CDG_COORD_W-1:0] voxel_x;
      logic [CDG_COORD_W-1:0] voxel_y;
      logic [CDG_COORD_W-1:0] voxel_z;
      logic [CDG_VOXEL_W-1:0] left_value;
      logic [CDG_VOXEL_W-1:0] right_value;
      logic [CDG_VOXEL_W-1:0] down_value;
      logic [CDG_VOXEL_W-1:0] up_value;
      logic [CDG_VOXEL_W-1:0] back_value;
      logic [CDG_VOXEL_W-1:0] front_value;
   } cdg_req_type;

   typedef struct packed {
      logic [CDG_COORD_W-1:0]        tag_x;
      logic [CDG_COORD_W-1:0]        tag_y;
      logic [CDG_COORD_W-1:0]        tag_z;
      logic signed [CDG_GRAD_W-1:0]  grad_x;
      logic signed [CDG_GRAD_W-1:0]  grad_y;
      logic signed [CDG_GRAD_W-1:0]  grad_z;
      logic                          zero_gradient;
   } cdg_rsp_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } cdg_side_type;

   // front end 3, divider 2F+3, root F+2, rounding 1, output 1
   function automatic int cdg_latency(input int fb);
      return 3 * fb + 10;
   endfunction

endpackage

/* design/cdg_diff.sv */
// Front end: axis differences, magnitudes, squares and sum of squares.
module cdg_diff #(
   parameter int VB = 8
) (
   input  logic                      clock,
   input  logic [2:0][VB-1:0]        lo,
   input  logic [2:0][VB-1:0]        hi,
   output logic [2:0][2*VB-1:0]      dsq,
   output logic [2*VB+1:0]           sum_sq,
   output cdg_pkg::cdg_side_type     side
);
   import cdg_pkg::*;

   localparam int SW = 2 * VB + 2;

   logic [2:0][VB-1:0]   abs_ff;
   logic [2:0][VB-1:0]   abs_in;
   logic [2:0]           neg1_ff;
   logic [2:0]           neg1_in;
   logic [2:0][2*VB-1:0] sq_ff;
   logic [2:0]           neg2_ff;
   logic [2:0][2*VB-1:0] dsq_ff;
   logic [SW-1:0]        sum_ff;
   logic [SW-1:0]        sum_in;
   cdg_side_type         side_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic [VB:0] dif;
         logic [VB:0] mag;
         dif = {1'b0, lo[a]} - {1'b0, hi[a]};
         mag = dif[VB] ? (~dif + 1'b1) : dif;
         neg1_in[a] = dif[VB];
         abs_in[a]  = mag[VB-1:0];
      end
   end

   assign sum_in = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);

   always_ff @(posedge clock) begin
      abs_ff  <= abs_in;
      neg1_ff <= neg1_in;
      for (int a = 0; a < 3; a++) begin
         sq_ff[a] <= abs_ff[a] * abs_ff[a];
      end
      neg2_ff      <= neg1_ff;
      dsq_ff       <= sq_ff;
      sum_ff       <= sum_in;
      side_ff.neg  <= neg2_ff;
      side_ff.zero <= (sum_in == '0);
   end

   assign dsq    = dsq_ff;
   assign sum_sq = sum_ff;
   assign side   = side_ff;

endmodule

/* design/cdg_div.sv */
// Pipelined restoring divider: floor(dsq * 2^(2F+2) / s), one quotient bit per stage.
module cdg_div #(
   parameter int VB = 8,
   parameter int FB = 14
) (
   input  logic                clock,
   input  logic [2*VB-1:0]     dsq,
   input  logic [2*VB+1:0]     sum_sq,
   output logic [2*FB+2:0]     quo
);
   import cdg_pkg::*;

   localparam int SW = 2 * VB + 2;
   localparam int PW = SW + 1;
   localparam int QW = 2 * FB + 3;

   logic [SW-1:0] rem_ff [QW];
   logic [SW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [PW-1:0] part;
      logic [PW-1:0] dvs;
      logic [QW-1:0] prev_q;
      logic          ge;
      if (i == 0) begin : g_first
         assign part   = PW'(dsq);
         assign dvs    = PW'(sum_sq);
         assign prev_q = '0;
      end else begin : g_next
         assign part   = {rem_ff[i-1], 1'b0};
         assign dvs    = {1'b0, den_ff[i-1]};
         assign prev_q = quo_ff[i-1];
      end
      assign ge = (part >= dvs);
      always_ff @(posedge clock) begin
         rem_ff[i] <= ge ? SW'(part - dvs) : SW'(part);
         den_ff[i] <= dvs[SW-1:0];
         quo_ff[i] <= {prev_q[QW-2:0], ge};
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

/* design/cdg_sqrt.sv */
// Pipelined integer square root, two radicand bits per stage, then halving round.
module cdg_sqrt #(
   parameter int FB = 14
) (
   input  logic            clock,
   input  logic [2*FB+2:0] rad,
   output logic [FB:0]     mag
);
   import cdg_pkg::*;

   localparam int NW = 2 * FB + 4;
   localparam int N  = FB + 2;
   localparam int RW = FB + 3;
   localparam int XW = FB + 5;
   localparam int KW = FB + 3;

   logic [NW-1:0] val_ff  [N];
   logic [RW-1:0] rem_ff  [N];
   logic [N-1:0]  root_ff [N];
   logic [FB:0]   mag_ff;
   logic [KW-1:0] kp;

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [NW-1:0] pval;
      logic [RW-1:0] prem;
      logic [N-1:0]  proot;
      logic [XW-1:0] x;
      logic [XW-1:0] trial;
      logic          ge;
      if (i == 0) begin : g_first
         assign pval  = NW'(rad);
         assign prem  = '0;
         assign proot = '0;
      end else begin : g_next
         assign pval  = val_ff[i-1];
         assign prem  = rem_ff[i-1];
         assign proot = root_ff[i-1];
      end
      assign x     = {prem, pval[NW-1:NW-2]};
      assign trial = XW'({proot, 2'b01});
      assign ge    = (x >= trial);
      always_ff @(posedge clock) begin
         val_ff[i]  <= {pval[NW-3:0], 2'b00};
         rem_ff[i]  <= ge ? RW'(x - trial) : RW'(x);
         root_ff[i] <= {proot[N-2:0], ge};
      end
   end

   assign kp = KW'(root_ff[N-1]) + KW'(1);

   always_ff @(posedge clock) begin
      mag_ff <= kp[FB+1:1];
   end

   assign mag = mag_ff;

endmodule

/* design/central_difference_gradient.sv */
// Top level: normalized central difference gradient, one voxel per clock.
//
//   channel   ports                  direction   beat taken when
//   request   start, busy, req_data  in          start && !busy
//   response  rsp_valid, rsp_data    out         rsp_valid (one cycle)
//
// The pipeline holds 3 front-end stages, a 2F+3 stage divider, an F+2 stage root,
// a rounding stage and the output register. One beat is accepted every cycle
// while busy is low; busy is high only during reset and the cycle after.
// Synchronous reset clears valid bits and sets busy; the datapath carries no reset.
// The response side cannot stall, so the pipeline never holds.
module central_difference_gradient #(
   parameter int VOXEL_BITS    = cdg_pkg::VOXEL_BITS_DEF,
   parameter int COORD_BITS    = cdg_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = cdg_pkg::FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cdg_pkg::cdg_req_type req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output cdg_pkg::cdg_rsp_type rsp_data
);
   import cdg_pkg::*;

   localparam int VB  = VOXEL_BITS;
   localparam int FB  = FRACTION_BITS;
   localparam int QW  = 2 * FB + 3;
   localparam int LAT = cdg_latency(FB);
   localparam int TL  = LAT - 1;
   localparam int SL  = QW + FB + 3;

   typedef struct packed {
      logic                   valid;
      logic [CDG_COORD_W-1:0] x;
      logic [CDG_COORD_W-1:0] y;
      logic [CDG_COORD_W-1:0] z;
   } cdg_tag_type;

   logic [2:0][VB-1:0]   lo;
   logic [2:0][VB-1:0]   hi;
   logic [2:0][2*VB-1:0] dsq;
   logic [2*VB+1:0]      sum_sq;
   cdg_side_type         side;
   logic [2:0][QW-1:0]   quo;
   logic [2:0][FB:0]     mag;

   cdg_tag_type  tag_ff  [TL];
   cdg_tag_type  tag_in;
   cdg_side_type side_ff [SL];
   logic         busy_ff;
   logic         rsp_valid_ff;
   cdg_rsp_type  rsp_ff;
   cdg_rsp_type  rsp_in;

   assign lo[0] = VB'(req_data.left_value);
   assign hi[0] = VB'(req_data.right_value);
   assign lo[1] = VB'(req_data.down_value);
   assign hi[1] = VB'(req_data.up_value);
   assign lo[2] = VB'(req_data.back_value);
   assign hi[2] = VB'(req_data.front_value);

   cdg_diff #(.VB(VB)) u_diff (
      .clock  (clock),
      .lo     (lo),
      .hi     (hi),
      .dsq    (dsq),
      .sum_sq (sum_sq),
      .side   (side)
   );

   for (genvar a = 0; a < 3; a++) begin : g_axis
      cdg_div #(.VB(VB), .FB(FB)) u_div (
         .clock  (clock),
         .dsq    (dsq[a]),
         .sum_sq (sum_sq),
         .quo    (quo[a])
      );
      cdg_sqrt #(.FB(FB)) u_sqrt (
         .clock (clock),
         .rad   (quo[a]),
         .mag   (mag[a])
      );
   end

   assign tag_in.valid = start && !busy_ff;
   assign tag_in.x     = CDG_COORD_W'(COORD_BITS'(req_data.voxel_x));
   assign tag_in.y     = CDG_COORD_W'(COORD_BITS'(req_data.voxel_y));
   assign tag_in.z     = CDG_COORD_W'(COORD_BITS'(req_data.voxel_z));

   always_comb begin
      logic [2:0][CDG_GRAD_W-1:0] g;
      cdg_side_type               sd;
      sd = side_ff[SL-1];
      for (int a = 0; a < 3; a++) begin
         g[a] = CDG_GRAD_W'(mag[a]);
         if (sd.zero) begin
            g[a] = '0;
         end else if (sd.neg[a]) begin
            g[a] = ~g[a] + 1'b1;
         end
      end
      rsp_in.tag_x         = tag_ff[TL-1].x;
      rsp_in.tag_y         = tag_ff[TL-1].y;
      rsp_in.tag_z         = tag_ff[TL-1].z;
      rsp_in.grad_x        = g[0];
      rsp_in.grad_y        = g[1];
      rsp_in.grad_z        = g[2];
      rsp_in.zero_gradient = sd.zero;
   end

   always_ff @(posedge clock) begin
      tag_ff[0].x <= tag_in.x;
      tag_ff[0].y <= tag_in.y;
      tag_ff[0].z <= tag_in.z;
      for (int i = 1; i < TL; i++) begin
         tag_ff[i].x <= tag_ff[i-1].x;
         tag_ff[i].y <= tag_ff[i-1].y;
         tag_ff[i].z <= tag_ff[i-1].z;
      end
      if (reset) begin
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TL; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
      end else begin
         busy_ff         <= 1'b0;
         rsp_valid_ff    <= tag_ff[TL-1].valid;
         tag_ff[0].valid <= tag_in.valid;
         for (int i = 1; i < TL; i++) begin
            tag_ff[i].valid <= tag_ff[i-1].valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side;
      for (int i = 1; i < SL; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* design/cdg_checker.sv */
// Port-level checks for the gradient block, bound to the top level.
`include "central_difference_gradient_macros.svh"

module cdg_checker #(
   parameter int LAT = 52
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input cdg_pkg::cdg_rsp_type rsp_data
);
   import cdg_pkg::*;

   `CDG_ASSERT_NEXT(a_beat_answered, clock, reset, start && !busy, ##(LAT-1) rsp_valid, "accepted beat produced no response")
   `CDG_ASSERT_IMP(a_no_spurious, clock, reset, rsp_valid, $past(start && !busy, LAT), "response without a matching request")
   `CDG_ASSERT_IMP(a_zero_clears, clock, reset, rsp_valid && rsp_data.zero_gradient, rsp_data.grad_x == '0 && rsp_data.grad_y == '0 && rsp_data.grad_z == '0, "zero gradient with nonzero components")
   `CDG_ASSERT_IMP(a_nonzero_has_comp, clock, reset, rsp_valid && !rsp_data.zero_gradient, rsp_data.grad_x != '0 || rsp_data.grad_y != '0 || rsp_data.grad_z != '0, "nonzero gradient normalized to all zeros")

endmodule

bind central_difference_gradient cdg_checker #(
   .LAT(cdg_pkg::cdg_latency(FRACTION_BITS))
) u_cdg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
